// File: hdl/cppt_pkg.sv
// Shared types and constants for the convex polygon point test block.
package cppt_pkg;

	// Field widths that the stream format fixes.
	localparam int IDX_W  = 4;
	localparam int KIND_W = 1;
	localparam int CNT_REG_W = 5;
	localparam int OUT_W  = 8;

	// Item kinds carried in tuser.
	localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
	localparam logic [KIND_W-1:0] KIND_TEST = 1'b1;

	// Configuration port.
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_VERTEX_COUNT = 2'd0;

	// A polygon needs this many vertices before a point can lie inside it.
	localparam int MIN_VERTICES = 3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // latch the test point and clear the side flags
		logic degen;     // with start: too few vertices, force an outside answer
		logic load;      // write a vertex into the table
		logic rd_en;     // read one table entry
		logic rd_first;  // the entry read is vertex 0 of the walk
		logic rd_last;   // the entry read closes the polygon
		logic out_load;  // move the answer into the output register
	} cppt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_done;  // last edge folded into the side flags this cycle
		logic out_full;  // output register holds a beat that is not taken
	} cppt_status_t;

endpackage

// File: hdl/convex_polygon_point_test.sv
// Top level of the convex polygon point test: stream ports, register port, submodules.
//
//  Channel | Group             | Carries
//  --------+-------------------+----------------------------------------------
//  input   | s_tvalid/s_tready | load a vertex or test a point, one per beat
//  output  | m_tvalid/m_tready | inside answer, one beat per test
//  config  | APB               | vertex_count at byte address 0
//
// For a test with n vertices in use,
// the vertex memory's single read port delivers one vertex per cycle for n + 1 reads,
// followed by the read, multiply and compare stages and the output load.
// With fewer than three vertices a test skips the walk. A new beat is accepted
// only between tests; a waiting answer holds the next test in its last cycle, and no
// beat is accepted until that answer is taken.
// Reset clears the control state and vertex_count; the vertex table is not cleared.
module convex_polygon_point_test #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata from bit 0: vertex_index[3:0], coord_x, coord_y, zero fill
	input  logic [((cppt_pkg::IDX_W + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// s_tuser: kind
	input  logic [cppt_pkg::KIND_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata from bit 0: inside_res, zero fill
	output logic [cppt_pkg::OUT_W-1:0]       m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cppt_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [cppt_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [cppt_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import cppt_pkg::*;

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;

	logic [CNT_REG_W-1:0] vertex_count_q;
	logic [CMP_W-1:0]     count_ext;
	logic [CNT_W-1:0]     vertex_num;
	logic                 apb_write;

	logic [IDX_W-1:0]      in_index;
	logic [COORD_BITS-1:0] in_x, in_y;
	logic [AW-1:0]         rd_addr;
	logic                  out_inside;
	cppt_cmd_t             cmd;
	cppt_status_t          status;

	// The single register is written from every address the port can reach; it reads back only at address 0.
	assign pready    = 1'b1;
	assign apb_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (apb_write) begin
			vertex_count_q <= pwdata[CNT_REG_W-1:0];
		end
	end

	assign prdata = (paddr == REG_VERTEX_COUNT) ?
		{{(APB_DATA_W - CNT_REG_W){1'b0}}, vertex_count_q} : '0;

	// A count above the table depth uses the whole table.
	assign count_ext  = CMP_W'(vertex_count_q);
	assign vertex_num = (count_ext > CMP_W'(MAX_VERTICES)) ?
		CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_q);

	assign in_index = s_tdata[IDX_W-1:0];
	assign in_x     = s_tdata[IDX_W +: COORD_BITS];
	assign in_y     = s_tdata[IDX_W + COORD_BITS +: COORD_BITS];

	cppt_ctrl #(
		.CNT_W(CNT_W),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind(s_tuser),
		.vertex_num(vertex_num),
		.status(status),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	cppt_dpath #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS(COORD_BITS),
		.AW(AW)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.rd_addr(rd_addr),
		.in_index(in_index),
		.in_x(in_x),
		.in_y(in_y),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_inside(out_inside)
	);

	assign m_tdata = {{(OUT_W - 1){1'b0}}, out_inside};

endmodule

// File: hdl/cppt_ctrl.sv
// Controller: accepts items and sequences the vertex walk of a point test.
module cppt_ctrl #(
	parameter int CNT_W = 5,
	parameter int AW = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [cppt_pkg::KIND_W-1:0] in_kind,
	input  logic [CNT_W-1:0]       vertex_num,
	input  cppt_pkg::cppt_status_t status,
	output cppt_pkg::cppt_cmd_t    cmd,
	output logic [AW-1:0]          rd_addr
);
	import cppt_pkg::*;

	localparam int STATE_W = 2;
	localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
	localparam logic [STATE_W-1:0] ST_RUN    = 2'd1;
	localparam logic [STATE_W-1:0] ST_WAIT   = 2'd2;
	localparam logic [STATE_W-1:0] ST_FINISH = 2'd3;

	logic [STATE_W-1:0] state_q, state_d;
	logic [CNT_W-1:0]   step_q, step_d;
	logic               accept;
	logic               is_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_last  = (step_q == vertex_num);

	// The walk reads vertices 0 to n-1 and then vertex 0 again for the closing edge.
	assign rd_addr = is_last ? '0 : step_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (accept) begin
					if (in_kind == KIND_TEST) begin
						cmd.start = 1'b1;
						if (vertex_num < CNT_W'(MIN_VERTICES)) begin
							cmd.degen = 1'b1;
							state_d   = ST_FINISH;
						end else begin
							state_d = ST_RUN;
						end
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_RUN: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (step_q == '0);
				cmd.rd_last  = is_last;
				step_d       = step_q + 1'b1;
				if (is_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.acc_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

// File: hdl/cppt_dpath.sv
// Datapath: vertex memory, edge orientation pipeline, side flags and output register.
module cppt_dpath #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 16,
	parameter int AW = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cppt_pkg::cppt_cmd_t         cmd,
	output cppt_pkg::cppt_status_t      status,
	input  logic [AW-1:0]               rd_addr,
	input  logic [cppt_pkg::IDX_W-1:0]  in_index,
	input  logic [COORD_BITS-1:0]       in_x,
	input  logic [COORD_BITS-1:0]       in_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_inside
);
	import cppt_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int PW = 2 * C + 2;

	logic [2*C-1:0] vtx_mem_q [MAX_VERTICES];

	logic [IW-1:0]  idx_ext;
	logic           idx_ok;

	logic [C-1:0]   px_q, py_q;
	logic [C-1:0]   prev_x_q, prev_y_q;

	logic [C-1:0]   rd_x_s1, rd_y_s1;
	logic           rd_vld_s1, first_s1, last_s1;

	logic signed [C:0]    dax, day, dbx, dby;
	logic signed [PW-1:0] prod_p_s2, prod_q_s2;
	logic                 edge_vld_s2, last_s2;

	logic any_left_q, any_right_q;
	logic edge_left;
	logic out_valid_q, out_inside_q;

	// Slots beyond the table depth are dropped.
	assign idx_ext = IW'(in_index);
	assign idx_ok  = idx_ext < IW'(MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok) begin
			vtx_mem_q[idx_ext[AW-1:0]] <= {in_y, in_x};
		end
		if (cmd.rd_en) begin
			{rd_y_s1, rd_x_s1} <= vtx_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			edge_vld_s2 <= 1'b0;
			last_s2     <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.rd_en;
			first_s1    <= cmd.rd_first;
			last_s1     <= cmd.rd_last;
			edge_vld_s2 <= rd_vld_s1 && !first_s1;
			last_s2     <= rd_vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= in_x;
			py_q <= in_y;
		end
		if (rd_vld_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
	end

	// Edge from the previous vertex (a) to the one just read (b), both relative to the point.
	assign dax = $signed({prev_x_q[C-1], prev_x_q}) - $signed({px_q[C-1], px_q});
	assign day = $signed({prev_y_q[C-1], prev_y_q}) - $signed({py_q[C-1], py_q});
	assign dbx = $signed({rd_x_s1[C-1], rd_x_s1}) - $signed({px_q[C-1], px_q});
	assign dby = $signed({rd_y_s1[C-1], rd_y_s1}) - $signed({py_q[C-1], py_q});

	always_ff @(posedge clk) begin
		prod_p_s2 <= PW'(dax) * PW'(dby);
		prod_q_s2 <= PW'(day) * PW'(dbx);
	end

	// The cross product is negative exactly when the first product is below the second.
	assign edge_left = prod_p_s2 < prod_q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_left_q  <= 1'b0;
			any_right_q <= 1'b0;
		end else if (cmd.start) begin
			// Too few vertices: both flags set make the answer outside.
			any_left_q  <= cmd.degen;
			any_right_q <= cmd.degen;
		end else if (edge_vld_s2) begin
			if (edge_left) begin
				any_left_q <= 1'b1;
			end else begin
				any_right_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_inside_q <= !(any_left_q && any_right_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign out_inside      = out_inside_q;
	assign status.acc_done = last_s2;
	assign status.out_full = out_valid_q && !out_ready;

endmodule

// File: dv/tb_convex_polygon_point_test.sv
// Self-checking testbench for the convex polygon point test block.
module tb_convex_polygon_point_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cppt_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int DEPTH = 16;
	localparam int CW = 16;
	localparam int SD_W = ((IDX_W + 2*CW + 7) / 8) * 8;
	localparam int RAND_ITEMS = 500;
	localparam int DRAIN_CYC = 40;
	localparam int HOLD_CYC = 400;
	localparam int HOLD_AT = 150;
	localparam int STALL_LIMIT = 3000;
	localparam int IDLE_PCT = 34;

	typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         rk;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		bit                fixed;
		bit                fixed_val;
		int                cfg_val;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// s_tdata from bit 0: vertex_index[3:0], coord_x, coord_y, zero fill
	logic [SD_W-1:0] s_tdata;
	// s_tuser: kind
	logic [KIND_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// m_tdata from bit 0: inside_res, zero fill
	logic [OUT_W-1:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// Predictor state: its own copy of the vertex table and the count register.
	logic signed [CW-1:0] vx_tbl [DEPTH];
	logic signed [CW-1:0] vy_tbl [DEPTH];
	logic [CNT_REG_W-1:0] poly_count;

	bit inside_q [$];
	dir_row_t dir_rows [$];
	int err_cnt = 0;
	int n_beats = 0;
	int n_answers = 0;
	int stall_cyc = 0;
	bit calm = 1'b0;
	bit held = 1'b0;
	int cos_tbl [16] = '{1000, 924, 707, 383, 0, -383, -707, -924,
		-1000, -924, -707, -383, 0, 383, 707, 924};

	always #(CLK_PERIOD/2) clk = ~clk;

	convex_polygon_point_test #(
		.MAX_VERTICES(DEPTH),
		.COORD_BITS(CW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// A point is inside when every edge, the closing edge included, sees it on one side.
	function automatic bit calc_inside(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
		int n;
		int j;
		longint cr;
		bit seen_l;
		bit seen_r;
		n = (poly_count > DEPTH) ? DEPTH : int'(poly_count);
		seen_l = 1'b0;
		seen_r = 1'b0;
		if (n < MIN_VERTICES)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			cr = (longint'(vx_tbl[i]) - px) * (longint'(vy_tbl[j]) - py)
				- (longint'(vy_tbl[i]) - py) * (longint'(vx_tbl[j]) - px);
			if (cr < 0)
				seen_l = 1'b1;
			else
				seen_r = 1'b1;
		end
		return !(seen_l && seen_r);
	endfunction

	function automatic logic signed [CW-1:0] clip16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[CW-1:0];
	endfunction

	task automatic add_beat(logic [KIND_W-1:0] kind, int idx, int x, int y,
			bit fixed = 1'b0, bit fixed_val = 1'b0);
		dir_row_t r;
		r.rk = ROW_BEAT;
		r.kind = kind;
		r.idx = idx[IDX_W-1:0];
		r.x = clip16(x);
		r.y = clip16(y);
		r.fixed = fixed;
		r.fixed_val = fixed_val;
		r.cfg_val = 0;
		dir_rows = {dir_rows, r};
	endtask

	task automatic add_cfg(int value);
		dir_row_t r;
		r = '{ROW_CFG, KIND_LOAD, '0, '0, '0, 1'b0, 1'b0, value};
		dir_rows = {dir_rows, r};
	endtask

	// Offers one beat, waits for the handshake and updates the predictor.
	task automatic send_beat(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
			logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			bit fixed = 1'b0, bit fixed_val = 1'b0);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(SD_W - IDX_W - 2*CW){1'b0}}, y, x, idx};
		do @(posedge clk); while (!s_tready);
		n_beats++;
		if (kind == KIND_LOAD) begin
			vx_tbl[idx] = x;
			vy_tbl[idx] = y;
		end else begin
			inside_q = {inside_q, (fixed ? fixed_val : calc_inside(x, y))};
		end
	endtask

	// Writes vertex_count once the block is idle, then reads it back.
	task automatic write_count(int value);
		s_tvalid <= 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_VERTEX_COUNT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		poly_count = value[CNT_REG_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(value)) begin
			$display("%0t: vertex_count readback mismatch, expected %0d, got %0d",
				$time, value, prdata);
			err_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase();
		int r;
		int cnt;
		int n;
		int need;
		int s;
		int nt;
		int cx;
		int cy;
		int rad;
		int span;
		int b;
		int pgx [DEPTH];
		int pgy [DEPTH];
		bit rev;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		r = $urandom_range(9);
		case (r)
			0: cnt = 0;
			1: cnt = $urandom_range(1, 2);
			2: cnt = DEPTH;
			3: cnt = $urandom_range(DEPTH + 1, 31);
			4: cnt = 31;
			default: cnt = $urandom_range(MIN_VERTICES, DEPTH);
		endcase
		write_count(cnt);
		n = (cnt > DEPTH) ? DEPTH : cnt;

		// Noise phase, or too few vertices for a polygon: raw random beats.
		if (n < MIN_VERTICES || $urandom_range(3) == 0) begin
			nt = $urandom_range(8, 20);
			for (int k = 0; k < nt; k++)
				send_beat(KIND_W'($urandom_range(1)), 4'($urandom()), 16'($urandom()),
					16'($urandom()));
			return;
		end

		// Convex polygon: an ordered subset of sixteen points on a circle.
		cx = int'($urandom_range(16000)) - 8000;
		cy = int'($urandom_range(16000)) - 8000;
		rad = ($urandom_range(3) == 0) ? $urandom_range(1, 50) : $urandom_range(100, 24000);
		rev = 1'($urandom_range(1));
		need = n;
		s = 0;
		for (int a = 0; a < DEPTH; a++) begin
			if ($urandom_range(DEPTH - 1 - a) < need) begin
				b = rev ? n - 1 - s : s;
				pgx[b] = cx + rad * cos_tbl[a] / 1000;
				pgy[b] = cy + rad * cos_tbl[(a + 12) % 16] / 1000;
				s++;
				need--;
			end
		end
		for (int k = 0; k < n; k++)
			send_beat(KIND_LOAD, k[IDX_W-1:0], clip16(pgx[k]), clip16(pgy[k]));

		span = rad * 5 / 4 + 2;
		nt = $urandom_range(6, 18);
		for (int k = 0; k < nt; k++) begin
			r = $urandom_range(19);
			b = $urandom_range(n - 1);
			if (r < 2) begin
				// A stray load breaks the polygon for the rest of the phase.
				send_beat(KIND_LOAD, 4'($urandom()), 16'($urandom()), 16'($urandom()));
				continue;
			end else if (r < 4) begin
				px = clip16(pgx[b]);
				py = clip16(pgy[b]);
			end else if (r < 6) begin
				px = clip16((pgx[b] + pgx[(b + 1) % n]) / 2);
				py = clip16((pgy[b] + pgy[(b + 1) % n]) / 2);
			end else if (r < 8) begin
				px = 16'($urandom());
				py = 16'($urandom());
			end else begin
				px = clip16(cx + int'($urandom_range(2 * span)) - span);
				py = clip16(cy + int'($urandom_range(2 * span)) - span);
			end
			send_beat(KIND_TEST, 4'($urandom()), px, py);
		end
	endtask

	initial begin
		int dir_cnt;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= KIND_LOAD;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		poly_count = '0;

		// After reset no vertex is in use, so any point is outside.
		add_beat(KIND_TEST, 0, 0, 0, 1'b1, 1'b0);
		// Square at the coordinate extremes, counterclockwise.
		add_beat(KIND_LOAD, 0, -32768, -32768);
		add_beat(KIND_LOAD, 1, 32767, -32768);
		add_beat(KIND_LOAD, 2, 32767, 32767);
		add_beat(KIND_LOAD, 3, -32768, 32767);
		// The other slots repeat vertex 0, giving zero-length edges.
		for (int k = 4; k < DEPTH; k++)
			add_beat(KIND_LOAD, k, -32768, -32768);
		add_cfg(4);
		add_beat(KIND_TEST, 15, 0, 0);
		add_beat(KIND_TEST, 0, -32768, -32768);
		add_beat(KIND_TEST, 0, 32767, 0);
		add_cfg(3);
		add_beat(KIND_TEST, 0, -32768, 32767);
		add_beat(KIND_TEST, 0, 0, 0);
		add_cfg(2);
		add_beat(KIND_TEST, 0, 1234, -77, 1'b1, 1'b0);
		// A count above the table depth uses the whole table.
		add_cfg(31);
		add_beat(KIND_TEST, 0, 0, 0);
		add_beat(KIND_TEST, 0, -32768, 0);
		add_cfg(DEPTH);
		add_beat(KIND_TEST, 0, 100, -100);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].rk == ROW_CFG)
				write_count(dir_rows[i].cfg_val);
			else
				send_beat(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y,
					dir_rows[i].fixed, dir_rows[i].fixed_val);
		end

		dir_cnt = n_beats;
		while (n_beats < dir_cnt + RAND_ITEMS) begin
			calm = (n_beats >= dir_cnt + 250) && (n_beats < dir_cnt + 370);
			run_phase();
		end

		s_tvalid <= 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, and the answer check.
	initial begin
		bit want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n_answers++;
				if (inside_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got inside_res %0d",
						$time, m_tdata[0]);
					err_cnt++;
				end else begin
					want = inside_q.pop_front();
					if (m_tdata[0] !== want) begin
						$display("%0t: inside_res mismatch, expected %0d, got %0d",
							$time, want, m_tdata[0]);
						err_cnt++;
					end
				end
			end
			if (!held && n_answers >= HOLD_AT && s_tvalid) begin
				// The sender keeps offering, so the block fills and stalls its input.
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable && pready))
			stall_cyc = 0;
		else
			stall_cyc++;
		if (stall_cyc >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
